// ----- rtl/qlsg_pkg.sv -----
// Shared types, constants and width helpers for the quad Lagrange shape gradient block.
package qlsg_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_W          = 18;
  localparam int OUT_W         = 19;
  localparam int NODE_W        = 4;
  localparam int OUT_SAT       = 131072;

  typedef enum logic {
    ORDER_BILINEAR = 1'b0,
    ORDER_BIQUAD   = 1'b1
  } order_t;

  localparam order_t ORDER_RESET = ORDER_BIQUAD;

  localparam logic [NODE_W-1:0] LAST_NODE_BILIN  = 4'd3;
  localparam logic [NODE_W-1:0] LAST_NODE_BIQUAD = 4'd8;
  localparam logic [1:0]        LAST_COL_BILIN   = 2'd1;
  localparam logic [1:0]        LAST_COL_BIQUAD  = 2'd2;

  typedef struct packed {
    logic   valid;
    order_t order;
  } pt_ctrl_t;

  // width of 1.0 +- coordinate
  function automatic int sum_width(input int frac);
    return ((frac > IN_W - 1) ? frac : IN_W - 1) + 2;
  endfunction

  // width of a rounded 1-D factor
  function automatic int fac_width(input int frac);
    return 2 * sum_width(frac) - frac;
  endfunction

endpackage

// ----- rtl/qlsg_factor.sv -----
// Front pipeline: per point 1-D shape factors and slopes along xi and eta.
module qlsg_factor #(
  parameter int FRAC_BITS = qlsg_pkg::FRAC_BITS_DEF,
  localparam int SW = qlsg_pkg::sum_width(FRAC_BITS),
  localparam int AW = qlsg_pkg::fac_width(FRAC_BITS)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  qlsg_pkg::pt_ctrl_t              ctrl_in,
  input  logic signed [qlsg_pkg::IN_W-1:0] coord_in [2],
  output qlsg_pkg::pt_ctrl_t              ctrl_out,
  output logic signed [AW-1:0]            val_out [2][3],
  output logic signed [AW-1:0]            der_out [2][3]
);

  localparam int RW = 2 * SW + 1;
  localparam logic signed [SW-1:0] ONE       = SW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [AW-1:0] HALF      = AW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [AW-1:0] MINUS_ONE = AW'(-1);
  localparam logic signed [AW-1:0] PLUS_ONE  = AW'(1);

  // round to nearest, ties away from zero
  function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] v, input int k);
    logic signed [RW-1:0] half;
    logic signed [RW-1:0] bias;
    half = RW'(64'sd1 <<< (k - 1));
    bias = v[RW-1] ? (half - RW'(1)) : half;
    return (v + bias) >>> k;
  endfunction

  qlsg_pkg::pt_ctrl_t c1, c2;
  logic signed [qlsg_pkg::IN_W-1:0] x1 [2];
  logic signed [SW-1:0] xs [2], sm [2], sp [2];
  logic signed [SW-1:0] x2 [2], m2 [2], p2 [2];
  logic signed [2*SW-1:0] q2 [2][3];
  logic signed [RW-1:0] r0 [2], r1 [2], r2 [2];
  logic signed [AW-1:0] xa [2];
  logic signed [AW-1:0] val_next [2][3], der_next [2][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid       <= 1'b0;
      c2.valid       <= 1'b0;
      ctrl_out.valid <= 1'b0;
    end else if (adv) begin
      c1.valid       <= ctrl_in.valid;
      c2.valid       <= c1.valid;
      ctrl_out.valid <= c2.valid;
    end
    if (adv) begin
      c1.order       <= ctrl_in.order;
      c2.order       <= c1.order;
      ctrl_out.order <= c2.order;
      for (int d = 0; d < 2; d++) begin
        x1[d]    <= coord_in[d];
        x2[d]    <= xs[d];
        m2[d]    <= sm[d];
        p2[d]    <= sp[d];
        q2[d][0] <= xs[d] * sm[d];
        q2[d][1] <= sm[d] * sp[d];
        q2[d][2] <= sp[d] * xs[d];
        for (int n = 0; n < 3; n++) begin
          val_out[d][n] <= val_next[d][n];
          der_out[d][n] <= der_next[d][n];
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < 2; d++) begin
      xs[d] = SW'(x1[d]);
      sm[d] = ONE - xs[d];
      sp[d] = ONE + xs[d];
    end
  end

  always_comb begin
    for (int d = 0; d < 2; d++) begin
      r0[d] = rnd(-RW'(q2[d][0]), FRAC_BITS + 1);
      r1[d] = rnd(RW'(q2[d][1]), FRAC_BITS);
      r2[d] = rnd(RW'(q2[d][2]), FRAC_BITS + 1);
      xa[d] = AW'(x2[d]);
      if (c2.order == qlsg_pkg::ORDER_BIQUAD) begin
        val_next[d][0] = AW'(r0[d]);
        val_next[d][1] = AW'(r1[d]);
        val_next[d][2] = AW'(r2[d]);
        der_next[d][0] = xa[d] - HALF;
        der_next[d][1] = -(xa[d] <<< 1);
        der_next[d][2] = xa[d] + HALF;
      end else begin
        val_next[d][0] = AW'(m2[d]);
        val_next[d][1] = AW'(p2[d]);
        val_next[d][2] = '0;
        der_next[d][0] = MINUS_ONE;
        der_next[d][1] = PLUS_ONE;
        der_next[d][2] = '0;
      end
    end
  end

endmodule

// ----- rtl/qlsg_node.sv -----
// Node sequencer and per-node product, rounding and saturation pipeline.
module qlsg_node #(
  parameter int FRAC_BITS = qlsg_pkg::FRAC_BITS_DEF,
  localparam int AW = qlsg_pkg::fac_width(FRAC_BITS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  qlsg_pkg::pt_ctrl_t                 ctrl_in,
  input  logic signed [AW-1:0]               val_in [2][3],
  input  logic signed [AW-1:0]               der_in [2][3],
  output logic                               load,
  output logic                               node_valid,
  input  logic                               node_stall,
  output logic [qlsg_pkg::NODE_W-1:0]        node_index,
  output logic signed [qlsg_pkg::OUT_W-1:0]  shape_value,
  output logic signed [qlsg_pkg::OUT_W-1:0]  deriv_xi,
  output logic signed [qlsg_pkg::OUT_W-1:0]  deriv_eta,
  output logic                               last
);

  localparam int PW = 2 * AW;
  localparam logic signed [PW-1:0] SAT_HI = PW'(qlsg_pkg::OUT_SAT);
  localparam logic signed [PW-1:0] SAT_LO = -PW'(qlsg_pkg::OUT_SAT);

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int k);
    logic signed [PW-1:0] half;
    logic signed [PW-1:0] bias;
    half = PW'(64'sd1 <<< (k - 1));
    bias = v[PW-1] ? (half - PW'(1)) : half;
    return (v + bias) >>> k;
  endfunction

  function automatic logic signed [qlsg_pkg::OUT_W-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return c[qlsg_pkg::OUT_W-1:0];
  endfunction

  // held point
  logic                   busy;
  qlsg_pkg::order_t       horder;
  logic signed [AW-1:0]   hv [2][3], hd [2][3];
  logic [1:0]             ci, cj;
  logic [qlsg_pkg::NODE_W-1:0] k;
  logic                   nadv, issue, last_issue, col_last;

  // stage 1: operands
  logic                   v1, last1;
  qlsg_pkg::order_t       o1;
  logic [qlsg_pkg::NODE_W-1:0] k1;
  logic signed [AW-1:0]   op_a, op_b, op_da, op_db;

  // stage 2: products
  logic                   v2, last2;
  qlsg_pkg::order_t       o2;
  logic [qlsg_pkg::NODE_W-1:0] k2;
  logic signed [PW-1:0]   p_n, p_x, p_e;

  // stage 3: rounded
  logic                   v3, last3;
  logic [qlsg_pkg::NODE_W-1:0] k3;
  logic signed [PW-1:0]   r_n, r_x, r_e;

  assign nadv       = !node_valid || !node_stall;
  assign issue      = busy && nadv;
  assign last_issue = k == ((horder == qlsg_pkg::ORDER_BIQUAD) ?
                            qlsg_pkg::LAST_NODE_BIQUAD : qlsg_pkg::LAST_NODE_BILIN);
  assign col_last   = ci == ((horder == qlsg_pkg::ORDER_BIQUAD) ?
                             qlsg_pkg::LAST_COL_BIQUAD : qlsg_pkg::LAST_COL_BILIN);
  assign load       = ctrl_in.valid && (!busy || (issue && last_issue));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      node_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (issue && last_issue) begin
        busy <= 1'b0;
      end
      if (nadv) begin
        v1         <= issue;
        v2         <= v1;
        v3         <= v2;
        node_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      horder <= ctrl_in.order;
      ci     <= '0;
      cj     <= '0;
      k      <= '0;
      for (int d = 0; d < 2; d++) begin
        for (int n = 0; n < 3; n++) begin
          hv[d][n] <= val_in[d][n];
          hd[d][n] <= der_in[d][n];
        end
      end
    end else if (issue) begin
      k <= k + 1'b1;
      if (col_last) begin
        ci <= '0;
        cj <= cj + 1'b1;
      end else begin
        ci <= ci + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nadv) begin
      op_a  <= hv[0][ci];
      op_b  <= hv[1][cj];
      op_da <= hd[0][ci];
      op_db <= hd[1][cj];
      o1    <= horder;
      k1    <= k;
      last1 <= last_issue;

      p_n   <= op_a * op_b;
      p_x   <= op_da * op_b;
      p_e   <= op_a * op_db;
      o2    <= o1;
      k2    <= k1;
      last2 <= last1;

      if (o2 == qlsg_pkg::ORDER_BIQUAD) begin
        r_n <= rnd(p_n, FRAC_BITS);
        r_x <= rnd(p_x, FRAC_BITS);
        r_e <= rnd(p_e, FRAC_BITS);
      end else begin
        r_n <= rnd(p_n, FRAC_BITS + 2);
        r_x <= rnd(p_x, 2);
        r_e <= rnd(p_e, 2);
      end
      k3    <= k2;
      last3 <= last2;

      shape_value <= sat(r_n);
      deriv_xi    <= sat(r_x);
      deriv_eta   <= sat(r_e);
      node_index  <= k3;
      last        <= last3;
    end
  end

`ifndef NO_ASSERTIONS
  a_node_in_range: assert property (@(posedge clk) disable iff (rst)
    busy && horder == qlsg_pkg::ORDER_BILINEAR |-> k <= qlsg_pkg::LAST_NODE_BILIN)
    else $error("node counter past bilinear node count");

  a_last_tag: assert property (@(posedge clk) disable iff (rst)
    v1 && last1 |-> k1 == ((o1 == qlsg_pkg::ORDER_BIQUAD) ?
                           qlsg_pkg::LAST_NODE_BIQUAD : qlsg_pkg::LAST_NODE_BILIN))
    else $error("last flag on wrong node");

  a_load_when_done: assert property (@(posedge clk) disable iff (rst)
    load && busy |-> issue && last_issue)
    else $error("new point loaded over a running one");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    busy && !nadv |=> busy && $stable(k))
    else $error("sequencer moved while output stalled");
`endif

endmodule

// ----- rtl/quad_lagrange_shape_gradient.sv -----
// Top level: shape functions and parametric gradients of a 4- or 9-node Lagrange quad.
// Each point (xi, eta) transfer yields one node transfer per element node in ascending
// order, the final one tagged by last. Results leave at one node per cycle while
// node_stall is low, through a single set of three multipliers in the node sequencer;
// the next point is taken in the cycle its predecessor issues its final node. On its
// way from a point transfer to its first node, a point passes three front stages
// (capture, products, rounded factors), the point hold register of the node sequencer
// and four node stages (operand select, products, rounding, saturate). element_order
// is written through the cfg channel, resets to biquadratic and must only change while
// no point is in flight.
module quad_lagrange_shape_gradient #(
  parameter int FRAC_BITS = qlsg_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data,
  input  logic                               point_valid,
  output logic                               point_stall,
  input  logic signed [qlsg_pkg::IN_W-1:0]   xi,
  input  logic signed [qlsg_pkg::IN_W-1:0]   eta,
  output logic                               node_valid,
  input  logic                               node_stall,
  output logic [qlsg_pkg::NODE_W-1:0]        node_index,
  output logic signed [qlsg_pkg::OUT_W-1:0]  shape_value,
  output logic signed [qlsg_pkg::OUT_W-1:0]  deriv_xi,
  output logic signed [qlsg_pkg::OUT_W-1:0]  deriv_eta,
  output logic                               last
);

  localparam int AW = qlsg_pkg::fac_width(FRAC_BITS);

  qlsg_pkg::order_t   element_order;
  qlsg_pkg::pt_ctrl_t in_ctrl, fac_ctrl;
  logic signed [qlsg_pkg::IN_W-1:0] coord [2];
  logic signed [AW-1:0] fac_val [2][3], fac_der [2][3];
  logic load, fadv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_order <= qlsg_pkg::ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      element_order <= qlsg_pkg::order_t'(cfg_data);
    end
  end

  // front stages hold while the sequencer is still busy with the previous point
  assign fadv          = !fac_ctrl.valid || load;
  assign point_stall   = !fadv;
  assign in_ctrl.valid = point_valid;
  assign in_ctrl.order = element_order;
  assign coord[0]      = xi;
  assign coord[1]      = eta;

  qlsg_factor #(.FRAC_BITS(FRAC_BITS)) u_factor (
    .clk      (clk),
    .rst      (rst),
    .adv      (fadv),
    .ctrl_in  (in_ctrl),
    .coord_in (coord),
    .ctrl_out (fac_ctrl),
    .val_out  (fac_val),
    .der_out  (fac_der)
  );

  qlsg_node #(.FRAC_BITS(FRAC_BITS)) u_node (
    .clk         (clk),
    .rst         (rst),
    .ctrl_in     (fac_ctrl),
    .val_in      (fac_val),
    .der_in      (fac_der),
    .load        (load),
    .node_valid  (node_valid),
    .node_stall  (node_stall),
    .node_index  (node_index),
    .shape_value (shape_value),
    .deriv_xi    (deriv_xi),
    .deriv_eta   (deriv_eta),
    .last        (last)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the quad Lagrange shape and gradient block.
module tb_top;

  localparam int FB = qlsg_pkg::FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_DIR = 13;
  localparam int DIR_XI[N_DIR] = '{0, 65536, -65536, 65536, -65536, 32768, 1, 131071,
                                   -131072, 21845, 0, 2, 6};
  localparam int DIR_ETA[N_DIR] = '{0, 65536, -65536, -65536, 65536, -32768, -1, -131072,
                                    131071, 43690, 65536, -2, -6};

  typedef struct packed {
    logic [qlsg_pkg::NODE_W-1:0] idx;
    logic [qlsg_pkg::OUT_W-1:0]  n;
    logic [qlsg_pkg::OUT_W-1:0]  dx;
    logic [qlsg_pkg::OUT_W-1:0]  de;
    logic                        lst;
  } node_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic point_valid = 1'b0;
  logic point_stall;
  logic signed [qlsg_pkg::IN_W-1:0] xi = '0;
  logic signed [qlsg_pkg::IN_W-1:0] eta = '0;
  logic node_valid;
  logic node_stall = 1'b0;
  logic [qlsg_pkg::NODE_W-1:0] node_index;
  logic signed [qlsg_pkg::OUT_W-1:0] shape_value;
  logic signed [qlsg_pkg::OUT_W-1:0] deriv_xi;
  logic signed [qlsg_pkg::OUT_W-1:0] deriv_eta;
  logic last;

  qlsg_pkg::order_t cur_order = qlsg_pkg::ORDER_RESET;
  node_res_t exp_nodes[$];
  logic quiet = 1'b0;
  int err_count = 0;
  int points_sent = 0;
  int bilin_points = 0;
  int nodes_checked = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  quad_lagrange_shape_gradient u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .xi         (xi),
    .eta        (eta),
    .node_valid (node_valid),
    .node_stall (node_stall),
    .node_index (node_index),
    .shape_value(shape_value),
    .deriv_xi   (deriv_xi),
    .deriv_eta  (deriv_eta),
    .last       (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // divide by 2^k, round to nearest, ties away from zero
  function automatic longint round_shift(longint v, int k);
    longint half;
    half = longint'(1) <<< (k - 1);
    if (v >= 0) return (v + half) >>> k;
    return -((-v + half) >>> k);
  endfunction

  function automatic logic [qlsg_pkg::OUT_W-1:0] clamp_out(longint v);
    longint c;
    c = v;
    if (c > qlsg_pkg::OUT_SAT) c = qlsg_pkg::OUT_SAT;
    if (c < -qlsg_pkg::OUT_SAT) c = -qlsg_pkg::OUT_SAT;
    return c[qlsg_pkg::OUT_W-1:0];
  endfunction

  function automatic void predict_nodes(logic signed [qlsg_pkg::IN_W-1:0] x_in,
                                        logic signed [qlsg_pkg::IN_W-1:0] e_in,
                                        qlsg_pkg::order_t ord);
    longint s, x, e;
    longint fx[2], fe[2];
    longint a[3], b[3], da[3], db[3];
    longint n, dx, de;
    node_res_t r;
    int w;
    s = longint'(1) <<< FB;
    x = longint'(x_in);
    e = longint'(e_in);
    w = (ord == qlsg_pkg::ORDER_BILINEAR) ? 2 : 3;
    fx[0] = s - x; fx[1] = s + x;
    fe[0] = s - e; fe[1] = s + e;
    a[0] = round_shift(-(x * (s - x)), FB + 1);
    a[1] = round_shift((s - x) * (s + x), FB);
    a[2] = round_shift((s + x) * x, FB + 1);
    b[0] = round_shift(-(e * (s - e)), FB + 1);
    b[1] = round_shift((s - e) * (s + e), FB);
    b[2] = round_shift((s + e) * e, FB + 1);
    da[0] = x - s / 2; da[1] = -2 * x; da[2] = x + s / 2;
    db[0] = e - s / 2; db[1] = -2 * e; db[2] = e + s / 2;
    for (int j = 0; j < w; j++) begin
      for (int i = 0; i < w; i++) begin
        if (ord == qlsg_pkg::ORDER_BILINEAR) begin
          n  = round_shift(fx[i] * fe[j], FB + 2);
          dx = (i == 0) ? -round_shift(fe[j], 2) : round_shift(fe[j], 2);
          de = (j == 0) ? -round_shift(fx[i], 2) : round_shift(fx[i], 2);
        end else begin
          n  = round_shift(a[i] * b[j], FB);
          dx = round_shift(da[i] * b[j], FB);
          de = round_shift(a[i] * db[j], FB);
        end
        r.idx = qlsg_pkg::NODE_W'(i + w * j);
        r.n   = clamp_out(n);
        r.dx  = clamp_out(dx);
        r.de  = clamp_out(de);
        r.lst = (i + w * j == w * w - 1);
        exp_nodes.push_back(r);
      end
    end
  endfunction

  function automatic logic [qlsg_pkg::IN_W-1:0] rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return qlsg_pkg::IN_W'($urandom);
    if (sel < 16) begin
      case ($urandom_range(4))
        0: return qlsg_pkg::IN_W'(65536);
        1: return qlsg_pkg::IN_W'(-65536);
        2: return qlsg_pkg::IN_W'(0);
        3: return qlsg_pkg::IN_W'(32768);
        default: return qlsg_pkg::IN_W'(-32768);
      endcase
    end
    return qlsg_pkg::IN_W'(int'($urandom_range(131072)) - 65536);
  endfunction

  // caller sits at a falling edge; returns at the falling edge after the transfer
  task automatic send_point(logic [qlsg_pkg::IN_W-1:0] x_v, logic [qlsg_pkg::IN_W-1:0] e_v);
    if (!quiet && $urandom_range(99) < 12) begin
      point_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    point_valid = 1'b1;
    xi = x_v;
    eta = e_v;
    do @(posedge clk); while (point_stall);
    predict_nodes(x_v, e_v, cur_order);
    points_sent++;
    if (cur_order == qlsg_pkg::ORDER_BILINEAR) bilin_points++;
    @(negedge clk);
  endtask

  task automatic drain();
    point_valid = 1'b0;
    while (exp_nodes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_order(qlsg_pkg::order_t ord);
    drain();
    cfg_valid = 1'b1;
    cfg_data = ord;
    do @(posedge clk); while (!cfg_ready);
    cur_order = ord;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_directed();
    for (int k = 0; k < N_DIR; k++) begin
      send_point(qlsg_pkg::IN_W'(DIR_XI[k]), qlsg_pkg::IN_W'(DIR_ETA[k]));
    end
  endtask

  task automatic send_random(int count);
    for (int k = 0; k < count; k++) send_point(rand_coord(), rand_coord());
  endtask

  task automatic test_reset_biquad_directed();
    send_directed();
  endtask

  task automatic test_bilinear_directed();
    write_order(qlsg_pkg::ORDER_BILINEAR);
    send_directed();
  endtask

  task automatic test_biquad_random();
    write_order(qlsg_pkg::ORDER_BIQUAD);
    send_random(130);
  endtask

  task automatic test_bilinear_random();
    write_order(qlsg_pkg::ORDER_BILINEAR);
    send_random(130);
  endtask

  task automatic test_back_to_back();
    write_order(qlsg_pkg::ORDER_BIQUAD);
    quiet = 1'b1;
    send_random(50);
    drain();
    quiet = 1'b0;
  endtask

  task automatic test_order_switching();
    for (int p = 0; p < 8; p++) begin
      write_order(p[0] ? qlsg_pkg::ORDER_BIQUAD : qlsg_pkg::ORDER_BILINEAR);
      send_random(12);
    end
  endtask

  task automatic check_field(string name, logic [qlsg_pkg::OUT_W-1:0] exp_v,
                             logic [qlsg_pkg::OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch at node %0d: expected %0d actual %0d", $time, name,
               node_index, $signed(exp_v), $signed(act_v));
      err_count++;
    end
  endtask

  always @(negedge clk) begin
    node_stall <= !quiet && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    node_res_t r;
    if (!rst && node_valid && !node_stall) begin
      if (exp_nodes.size() == 0) begin
        $display("%0t: unexpected node transfer, node %0d", $time, node_index);
        err_count++;
      end else begin
        r = exp_nodes.pop_front();
        check_field("node_index", qlsg_pkg::OUT_W'(r.idx), qlsg_pkg::OUT_W'(node_index));
        check_field("shape_value", r.n, shape_value);
        check_field("deriv_xi", r.dx, deriv_xi);
        check_field("deriv_eta", r.de, deriv_eta);
        check_field("last", qlsg_pkg::OUT_W'(r.lst), qlsg_pkg::OUT_W'(last));
        nodes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (point_valid && !point_stall) || (node_valid && !node_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_biquad_directed();
    test_bilinear_directed();
    test_biquad_random();
    test_bilinear_random();
    test_back_to_back();
    test_order_switching();
    drain();
    repeat (20) @(posedge clk);
    if (exp_nodes.size() != 0) begin
      $display("%0t: %0d expected node transfers never arrived", $time, exp_nodes.size());
      err_count++;
    end
    $display("Covered %0d points (%0d bilinear, %0d biquadratic), %0d nodes checked,",
             points_sent, bilin_points, points_sent - bilin_points, nodes_checked);
    $display("%0d order writes, %0d mismatches", cfg_writes, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
